FILE: rtl/core/sia_pkg.sv
// Shared types and constants for the signed integer ALU.
// No dependencies.
package sia_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_SUB     = 3'd1,
        OP_MUL     = 3'd2,
        OP_DIV     = 3'd3,
        OP_MOD     = 3'd4,
        OP_LESS    = 3'd5,
        OP_GREATER = 3'd6,
        OP_NONE    = 3'd7
    } op_t;

endpackage

FILE: rtl/core/signed_integer_alu_top.sv
// Top level of the signed integer ALU: input stage, DATA_WIDTH divider
// stages, output stage. Depends on sia_pkg and sia_div_stage.

// Fully pipelined ALU taking one request per cycle while the pipe advances. Every
// result passes the input stage, DATA_WIDTH divider stages and the output stage,
// the restoring divider giving one quotient bit per stage; add, subtract, compare
// and multiply results ride alongside in the same pipeline so order holds.
// The whole pipe advances when the output is empty or being taken, so a
// stall freezes every stage and nothing is lost or repeated.
module signed_integer_alu_top #(
    parameter int DATA_WIDTH = sia_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   kind,
    input  logic signed [DATA_WIDTH-1:0] operand_a,
    input  logic signed [DATA_WIDTH-1:0] operand_b,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] value,
    output logic                         div_zero_error
);
    localparam int W = DATA_WIDTH;

    typedef struct packed {
        logic [2:0]   op;
        logic [W-1:0] res;
        logic         qneg;
        logic         rneg;
        logic         zero;
    } side_t;

    logic         adv;
    logic         v0_reg;
    side_t        s0_reg;
    logic [W-1:0] a0_reg;
    logic [W-1:0] b0_reg;
    side_t        side_reg [W];
    logic [W-1:0] dsr_reg  [W];
    logic         vv  [W+1];
    logic [W-1:0] rem [W+1];
    logic [W-1:0] quo [W+1];
    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;
    logic [W-1:0] early;
    logic [W-1:0] prod;
    logic [W-1:0] value_next;
    logic [W-1:0] value_reg;
    logic         err_next;
    logic         err_reg;
    logic         ov_reg;
    side_t        sl;

    // whole pipeline moves together
    assign adv      = !ov_reg || out_ready;
    assign in_ready = adv;

    assign mag_a = operand_a[W-1] ? (~operand_a + 1'b1) : operand_a;
    assign mag_b = operand_b[W-1] ? (~operand_b + 1'b1) : operand_b;
    assign prod  = operand_a * operand_b;

    // results that need no divider
    always_comb
    begin
        case (sia_pkg::op_t'(kind))
            sia_pkg::OP_ADD:     early = operand_a + operand_b;
            sia_pkg::OP_SUB:     early = operand_a - operand_b;
            sia_pkg::OP_MUL:     early = prod;
            sia_pkg::OP_LESS:    early = {{(W-1){1'b0}}, operand_a < operand_b};
            sia_pkg::OP_GREATER: early = {{(W-1){1'b0}}, operand_a > operand_b};
            default:             early = '0;
        endcase
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg.op   <= kind;
            s0_reg.res  <= early;
            s0_reg.qneg <= operand_a[W-1] ^ operand_b[W-1];
            s0_reg.rneg <= operand_a[W-1];
            s0_reg.zero <= (operand_b == '0);
            a0_reg      <= mag_a;
            b0_reg      <= mag_b;
        end
    end

    assign vv[0]  = v0_reg;
    assign rem[0] = '0;
    assign quo[0] = a0_reg;

    // divider stages with side data
    for (genvar i = 0; i < W; i++)
    begin : g_div
        sia_div_stage #(.W(W)) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .vin     (vv[i]),
            .rem_in  (rem[i]),
            .quo_in  (quo[i]),
            .dsr_in  ((i == 0) ? b0_reg : dsr_reg[(i == 0) ? 0 : i-1]),
            .vout    (vv[i+1]),
            .rem_out (rem[i+1]),
            .quo_out (quo[i+1])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[i] <= (i == 0) ? s0_reg : side_reg[(i == 0) ? 0 : i-1];
                dsr_reg[i]  <= (i == 0) ? b0_reg : dsr_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    assign sl = side_reg[W-1];

    // final sign fixup and select
    always_comb
    begin
        err_next   = 1'b0;
        value_next = sl.res;
        case (sia_pkg::op_t'(sl.op))
            sia_pkg::OP_DIV:
            begin
                err_next   = sl.zero;
                value_next = sl.zero ? '0 : (sl.qneg ? (~quo[W] + 1'b1) : quo[W]);
            end
            sia_pkg::OP_MOD:
            begin
                err_next   = sl.zero;
                value_next = sl.zero ? '0 : (sl.rneg ? (~rem[W] + 1'b1) : rem[W]);
            end
            default:
            begin
                value_next = sl.res;
            end
        endcase
    end

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            ov_reg <= vv[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg <= value_next;
            err_reg   <= err_next;
        end
    end

    assign out_valid      = ov_reg;
    assign value          = value_reg;
    assign div_zero_error = err_reg;

`ifndef ASSERT_OFF
    // an error result always carries value zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_zero_error |-> value == '0)
        else $error("error result with nonzero value");

    // a stalled output holds its result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(div_zero_error))
        else $error("stalled result changed");

    // the pipe accepts whenever the output is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipe blocked with empty output");
`endif
endmodule

FILE: rtl/core/sia_div_stage.sv
// One stage of the restoring divider pipeline: one quotient bit per stage.
// Depends on sia_pkg for the default data width.
module sia_div_stage #(
    parameter int W = sia_pkg::DATA_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         vin,
    input  logic [W-1:0] rem_in,
    input  logic [W-1:0] quo_in,
    input  logic [W-1:0] dsr_in,
    output logic         vout,
    output logic [W-1:0] rem_out,
    output logic [W-1:0] quo_out
);
    logic [W:0]   trial;
    logic [W:0]   diff;
    logic [W-1:0] rem_reg;
    logic [W-1:0] quo_reg;
    logic         v_reg;

    // shift in next dividend bit and try subtracting
    always_comb
    begin
        trial = {rem_in, quo_in[W-1]};
        diff  = trial - {1'b0, dsr_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (diff[W])
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_in[W-2:0], 1'b0};
            end
            else
            begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_in[W-2:0], 1'b1};
            end
        end
    end

    assign vout    = v_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
endmodule

FILE: test/alu_result_checker.sv
// Result checker for the signed integer ALU: watches both channels, predicts results.
// Depends on sia_pkg.
`timescale 1ns / 1ps
module alu_result_checker #(
    parameter int DATA_WIDTH = sia_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [2:0]                   kind,
    input  logic signed [DATA_WIDTH-1:0] operand_a,
    input  logic signed [DATA_WIDTH-1:0] operand_b,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         div_zero_error,
    output int                           error_count,
    output int                           pending_count
);
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         dz;
    } alu_result_t;

    alu_result_t expected_results[$];

    // Predict one ALU result from an operation and its operands
    function automatic alu_result_t compute_result(sia_pkg::op_t op,
                                                   logic [DATA_WIDTH-1:0] a,
                                                   logic [DATA_WIDTH-1:0] b);
        alu_result_t r;
        logic [DATA_WIDTH-1:0] mag_a, mag_b, q, rem;
        logic neg_a, neg_b;
        logic [2*DATA_WIDTH-1:0] prod;
        r = '0;
        neg_a = a[DATA_WIDTH-1];
        neg_b = b[DATA_WIDTH-1];
        mag_a = neg_a ? -a : a;
        mag_b = neg_b ? -b : b;
        case (op)
            sia_pkg::OP_ADD: r.value = a + b;
            sia_pkg::OP_SUB: r.value = a - b;
            sia_pkg::OP_MUL:
            begin
                prod = {{DATA_WIDTH{1'b0}}, a} * {{DATA_WIDTH{1'b0}}, b};
                r.value = prod[DATA_WIDTH-1:0];
            end
            sia_pkg::OP_DIV, sia_pkg::OP_MOD:
            begin
                if (b == '0)
                    r.dz = 1'b1;
                else
                begin
                    q = mag_a / mag_b;
                    rem = mag_a % mag_b;
                    if (op == sia_pkg::OP_DIV)
                        r.value = (neg_a != neg_b) ? -q : q;
                    else
                        r.value = neg_a ? -rem : rem;
                end
            end
            sia_pkg::OP_LESS:
                r.value = {{(DATA_WIDTH-1){1'b0}}, ($signed(a) < $signed(b))};
            sia_pkg::OP_GREATER:
                r.value = {{(DATA_WIDTH-1){1'b0}}, ($signed(a) > $signed(b))};
            default:    r = '0;
        endcase
        return r;
    endfunction

    assign pending_count = expected_results.size();

    // Queue predictions on accepted requests, compare accepted results
    always @(posedge clk or negedge rst_n)
    begin
        alu_result_t exp_r;
        if (!rst_n)
        begin
            error_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(
                    compute_result(sia_pkg::op_t'(kind), operand_a, operand_b));
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (error_count < 10)
                        $display("MISMATCH: unexpected result value=%0d err=%0b",
                                 value, div_zero_error);
                    error_count <= error_count + 1;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.value !== value || exp_r.dz !== div_zero_error)
                    begin
                        if (error_count < 10)
                            $display({"MISMATCH: expected value=%0d err=%0b, ",
                                      "got value=%0d err=%0b"},
                                     exp_r.value, exp_r.dz, value, div_zero_error);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: test/tb.sv
// Testbench top for the signed integer ALU: directed and random requests, verdict.
// Depends on sia_pkg, signed_integer_alu_top and alu_result_checker.
`timescale 1ns / 1ps
module tb;
    localparam int DW = 32;
    localparam int LATENCY = DW + 2;
    localparam int RANDOM_REQUESTS = 1000;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] kind = '0;
    logic signed [DW-1:0] operand_a = '0;
    logic signed [DW-1:0] operand_b = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [DW-1:0] value;
    logic div_zero_error;
    int error_count;
    int pending_count;
    int cycle_count = 0;
    logic quiet_phase = 1'b0;
    logic hold_done = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    signed_integer_alu_top #(.DATA_WIDTH(DW)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_ready(out_ready),
        .value(value), .div_zero_error(div_zero_error)
    );

    alu_result_checker #(.DATA_WIDTH(DW)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_ready(out_ready),
        .value(value), .div_zero_error(div_zero_error),
        .error_count(error_count), .pending_count(pending_count)
    );

    // Cycle limit guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: one long hold-off first, then random stalls outside the quiet phase
    initial
    begin
        int n;
        repeat (9) @(posedge clk);
        @(posedge clk);
        n = 0;
        while (n < 200)
        begin
            @(posedge clk);
            n++;
        end
        hold_done = 1'b1;
        forever
        begin
            out_ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 15);
            @(posedge clk);
        end
    end

    // Present one request and hold it until accepted
    task automatic send_request(sia_pkg::op_t op, logic [DW-1:0] a, logic [DW-1:0] b);
        if (!quiet_phase)
            while ($urandom_range(99) < 15)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        kind <= op;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Random operand biased toward edge values
    function automatic logic [DW-1:0] pick_operand();
        case ($urandom_range(9))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return '0;
            3: return {DW{1'b1}};
            4: return $urandom_range(7) - 3;
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        sia_pkg::op_t op;
        int k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every operation, zero divisor, MOST_NEG / -1, code seven
        send_request(sia_pkg::OP_ADD, MOST_POS, 1);
        send_request(sia_pkg::OP_SUB, MOST_NEG, 1);
        send_request(sia_pkg::OP_MUL, MOST_POS, MOST_POS);
        send_request(sia_pkg::OP_MUL, MOST_NEG, {DW{1'b1}});
        send_request(sia_pkg::OP_DIV, 7, 0);
        send_request(sia_pkg::OP_MOD, MOST_NEG, 0);
        send_request(sia_pkg::OP_DIV, MOST_NEG, {DW{1'b1}});
        send_request(sia_pkg::OP_MOD, MOST_NEG, {DW{1'b1}});
        send_request(sia_pkg::OP_DIV, -7, 2);
        send_request(sia_pkg::OP_MOD, -7, 2);
        send_request(sia_pkg::OP_DIV, 7, -2);
        send_request(sia_pkg::OP_MOD, 7, -2);
        send_request(sia_pkg::OP_DIV, MOST_POS, MOST_NEG);
        send_request(sia_pkg::OP_LESS, MOST_NEG, MOST_POS);
        send_request(sia_pkg::OP_LESS, MOST_POS, MOST_NEG);
        send_request(sia_pkg::OP_LESS, 5, 5);
        send_request(sia_pkg::OP_GREATER, MOST_POS, MOST_NEG);
        send_request(sia_pkg::OP_GREATER, {DW{1'b1}}, 0);
        send_request(sia_pkg::OP_NONE, MOST_POS, MOST_NEG);
        send_request(sia_pkg::OP_ADD, {DW{1'b1}}, {DW{1'b1}});

        // Random: requests 300 to 449 run with no sender or receiver idling
        for (k = 0; k < RANDOM_REQUESTS; k++)
        begin
            quiet_phase = hold_done && (k >= 300) && (k < 450);
            op = sia_pkg::op_t'(3'($urandom_range(7)));
            send_request(op, pick_operand(), pick_operand());
        end
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/sia_pkg.sv
rtl/core/sia_div_stage.sv
rtl/core/signed_integer_alu_top.sv
test/alu_result_checker.sv
test/tb.sv
